@@ hdl/key_matrix_debounce_scanner_assert.svh @@
// ---------------------------------------------------------------------------
// Key matrix debounce scanner: assertion macros
// Shared property forms for the port checker. Both use aclk; only KMDS_ASSERT_NEXT is disabled by aresetn.
// ---------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCE_SCANNER_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_SCANNER_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define KMDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("kmds: next-cycle property failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define KMDS_ASSERT_NEXT_ANY(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("kmds: property failed across reset");

`endif

@@ hdl/kmds_pkg.sv @@
// ---------------------------------------------------------------------------
// Key matrix debounce scanner: package
// Field widths, configuration register indexes, reset values and shared types.
// ---------------------------------------------------------------------------
package kmds_pkg;

    // Field widths of the transactions and registers.
    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;
    localparam int COLS_W    = 8;
    localparam int TIME_W    = 32;
    localparam int DEB_W     = 16;
    localparam int MASK_W    = 64;
    localparam int KEY_IDX_W = 6;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_COLS  = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MASK    = 1'd1;

    // Register reset values.
    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd5;
    localparam logic [MASK_W-1:0] KEY_MASK_RESET = 64'd0;

    // Per-row evaluation result: which keys change and their new level.
    typedef struct packed {
        logic [MAX_COLS-1:0] change;
        logic [MAX_COLS-1:0] level;
    } kmds_upd_t;

endpackage

@@ hdl/kmds_row_eval.sv @@
// ---------------------------------------------------------------------------
// Key matrix debounce scanner: row evaluation
// Decides for every column of one scanned row whether the key changes state.
// ---------------------------------------------------------------------------
module kmds_row_eval #(
    parameter int COLS = 8
) (
    input  logic                                     row_ok,
    input  logic [kmds_pkg::COLS_W-1:0]              col_closed,
    input  logic [kmds_pkg::TIME_W-1:0]              now,
    input  logic [kmds_pkg::DEB_W-1:0]               debounce_ms,
    input  logic [COLS-1:0]                          present,
    input  logic [COLS-1:0]                          down,
    input  logic [COLS-1:0][kmds_pkg::TIME_W-1:0]    change_time,
    output kmds_pkg::kmds_upd_t                      upd
);
    import kmds_pkg::*;

    // One independent check per column; columns beyond COLS never change.
    for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
        if (c < COLS) begin : g_used
            logic [TIME_W-1:0] elapsed;
            logic              settled;

            // Elapsed time wraps modulo 2^32 like the timestamp itself.
            assign elapsed = now - change_time[c];
            assign settled = elapsed >= TIME_W'(debounce_ms);
            assign upd.change[c] = row_ok && present[c] && settled &&
                                   (col_closed[c] != down[c]);
            assign upd.level[c]  = col_closed[c];
        end else begin : g_unused
            assign upd.change[c] = 1'b0;
            assign upd.level[c]  = 1'b0;
        end
    end

endmodule

@@ hdl/key_matrix_debounce_scanner.sv @@
// ---------------------------------------------------------------------------
// Key matrix debounce scanner
// Takes scanned matrix rows, debounces every populated key and reports each
// accepted press or release as one event, columns in ascending order.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Payload                                    | Unit
//  s_       | in        | s_row, s_col_closed, s_time_ms             | one row
//  m_       | out       | m_event_row, m_event_col, m_pressed,       | one event
//           |           | m_last_event                               |
//  cfg_     | in        | cfg_index, cfg_wr_data (write only)        | register
//
// A row is evaluated in the cycle in which it sits in the input register and the
// event buffer is free; its events then go into the event buffer, which drains
// one event per cycle while m_ready is high.
// A row without events leaves the buffer free, so such rows follow back to back.
// Reset is synchronous and active low; it clears the pressed bits and the row seen flags at once.
// A stall on m_ready holds the event buffer and then the input register.
// ---------------------------------------------------------------------------
module key_matrix_debounce_scanner #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration port
    input  logic                              cfg_wr_en,
    input  logic [kmds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kmds_pkg::MASK_W-1:0]       cfg_wr_data,
    // Scanned row input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [kmds_pkg::ROW_W-1:0]        s_row,
    input  logic [kmds_pkg::COLS_W-1:0]       s_col_closed,
    input  logic [kmds_pkg::TIME_W-1:0]       s_time_ms,
    // Key event output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [kmds_pkg::ROW_W-1:0]        m_event_row,
    output logic [kmds_pkg::COL_W-1:0]        m_event_col,
    output logic                              m_pressed,
    output logic                              m_last_event
);
    import kmds_pkg::*;

    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Configuration registers
    logic [DEB_W-1:0]  debounce_reg;
    logic [MASK_W-1:0] key_mask_reg;

    // Input register
    logic              in_valid_reg;
    logic [ROW_W-1:0]  in_row_reg;
    logic [COLS_W-1:0] in_cols_reg;
    logic [TIME_W-1:0] in_time_reg;

    // Key state: pressed bits and change times, one row per entry
    logic [COLS-1:0]              down_reg [ROWS];
    logic [COLS-1:0][TIME_W-1:0]  ct_reg [ROWS];
    logic [ROWS-1:0]              row_seen_reg;

    // Event buffer for the row being reported
    logic [MAX_COLS-1:0] pend_mask_reg;
    logic [MAX_COLS-1:0] pend_level_reg;
    logic [ROW_W-1:0]    pend_row_reg;

    logic [ROW_IDX_W-1:0]        row_idx;
    logic                        row_ok;
    logic [COLS-1:0]             present_row;
    logic [COLS-1:0]             down_row;
    logic [COLS-1:0][TIME_W-1:0] ct_row;
    kmds_upd_t                   upd;

    logic [MAX_COLS-1:0] low_bit;
    logic [MAX_COLS-1:0] pend_rest;
    logic [COL_W-1:0]    sel_col;
    logic                m_fire;
    logic                s_fire;
    logic                pend_free;
    logic                proc_fire;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            key_mask_reg <= KEY_MASK_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEBOUNCE_MS: debounce_reg <= cfg_wr_data[DEB_W-1:0];
                CFG_KEY_MASK:    key_mask_reg <= cfg_wr_data;
                default:         ;
            endcase
        end
    end

    // Read the state of the row held in the input register.
    assign row_idx = in_row_reg[ROW_IDX_W-1:0];
    assign row_ok  = {1'b0, in_row_reg} < (ROW_W + 1)'(ROWS);

    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            present_row[c] = key_mask_reg[KEY_IDX_W'(int'(row_idx) * COLS + c)];
        end
        if (row_ok) begin
            down_row = down_reg[row_idx];
            ct_row   = row_seen_reg[row_idx] ? ct_reg[row_idx] : '0;
        end else begin
            down_row = '0;
            ct_row   = '0;
        end
    end

    kmds_row_eval #(
        .COLS (COLS)
    ) u_row_eval (
        .row_ok      (row_ok),
        .col_closed  (in_cols_reg),
        .now         (in_time_reg),
        .debounce_ms (debounce_reg),
        .present     (present_row),
        .down        (down_row),
        .change_time (ct_row),
        .upd         (upd)
    );

    // Event selection: lowest pending column first.
    assign low_bit   = pend_mask_reg & (~pend_mask_reg + MAX_COLS'(1));
    assign pend_rest = pend_mask_reg & ~low_bit;

    always_comb begin
        sel_col = '0;
        for (int c = MAX_COLS - 1; c >= 0; c--) begin
            if (pend_mask_reg[c]) begin
                sel_col = COL_W'(c);
            end
        end
    end

    assign m_valid      = |pend_mask_reg;
    assign m_event_row  = pend_row_reg;
    assign m_event_col  = sel_col;
    assign m_pressed    = pend_level_reg[sel_col];
    assign m_last_event = (pend_rest == '0);

    // Handshake control
    assign m_fire    = m_valid && m_ready;
    assign pend_free = !m_valid || (m_ready && m_last_event);
    assign proc_fire = in_valid_reg && pend_free;
    assign s_ready   = !in_valid_reg || pend_free;
    assign s_fire    = s_valid && s_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_row_reg  <= s_row;
            in_cols_reg <= s_col_closed;
            in_time_reg <= s_time_ms;
        end
    end

    // Event buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_mask_reg <= '0;
        end else if (proc_fire) begin
            pend_mask_reg <= upd.change;
        end else if (m_fire) begin
            pend_mask_reg <= pend_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            pend_level_reg <= upd.level;
            pend_row_reg   <= in_row_reg;
        end
    end

    // Key state update when a row is evaluated.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_seen_reg <= '0;
            for (int r = 0; r < ROWS; r++) begin
                down_reg[r] <= '0;
            end
        end else if (proc_fire && row_ok) begin
            row_seen_reg[row_idx] <= 1'b1;
            for (int c = 0; c < COLS; c++) begin
                if (upd.change[c]) begin
                    down_reg[row_idx][c] <= upd.level[c];
                end
            end
        end
    end

    // Change times: the whole row is written so an unseen row starts at zero.
    always_ff @(posedge aclk) begin
        if (proc_fire && row_ok) begin
            for (int c = 0; c < COLS; c++) begin
                ct_reg[row_idx][c] <= upd.change[c] ? in_time_reg : ct_row[c];
            end
        end
    end

endmodule

@@ hdl/kmds_checker.sv @@
// ---------------------------------------------------------------------------
// Key matrix debounce scanner: port checker
// Watches the event channel of the top level over time.
// ---------------------------------------------------------------------------
`include "key_matrix_debounce_scanner_assert.svh"

module kmds_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [kmds_pkg::ROW_W-1:0]     m_event_row,
    input logic [kmds_pkg::COL_W-1:0]     m_event_col,
    input logic                           m_pressed,
    input logic                           m_last_event
);
    import kmds_pkg::*;

    // A stalled event stays offered unchanged.
    `KMDS_ASSERT_NEXT(a_event_hold, m_valid && !m_ready, m_valid && $stable(m_event_row) && $stable(m_event_col) && $stable(m_pressed) && $stable(m_last_event))

    // An event that is not the last of its row is followed by another one.
    `KMDS_ASSERT_NEXT(a_row_continues, m_valid && m_ready && !m_last_event, m_valid)

    // Events of one row come from the same row in ascending column order.
    `KMDS_ASSERT_NEXT(a_col_ascending, m_valid && m_ready && !m_last_event, m_event_row == $past(m_event_row) && m_event_col > $past(m_event_col))

    // No event is offered right after reset.
    `KMDS_ASSERT_NEXT_ANY(a_reset_idle, !aresetn, !m_valid)

endmodule

bind key_matrix_debounce_scanner kmds_checker u_kmds_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_event_row  (m_event_row),
    .m_event_col  (m_event_col),
    .m_pressed    (m_pressed),
    .m_last_event (m_last_event)
);
